@@ sv/linear_longest_prefix_match_macros.svh @@
// ============================================================================
// Assertion macros for the linear longest prefix match block
// Wraps concurrent assertions so that synthesis sees an empty body.
// ============================================================================
`ifndef LINEAR_LONGEST_PREFIX_MATCH_MACROS_SVH
`define LINEAR_LONGEST_PREFIX_MATCH_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, held off while reset is low.
`define LLPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define LLPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define LLPM_ASSERT(lbl, clk, rst_n, prop)
`define LLPM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ sv/llpm_pkg.sv @@
// ============================================================================
// llpm_pkg
// Constants and types shared by the route lookup engine.
// ============================================================================
package llpm_pkg;

    // Number of route slots held in the table.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Scan counter can hold the depth itself.
    localparam int CNT_W       = IDX_W + 1;

    // Field widths fixed by the interface.
    localparam int CFG_W       = 11;
    localparam int SLOT_W      = 10;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;

    localparam int S_TDATA_W   = 152;
    localparam int M_TDATA_W   = 56;

    // Operation codes carried in the input tuser bit.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // One stored route, as held in the table memory.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] hop;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] prefix;
    } t_route;

    localparam int ROUTE_W = $bits(t_route);

endpackage

@@ sv/llpm_ram.sv @@
// ============================================================================
// llpm_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ============================================================================
module llpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/linear_longest_prefix_match.sv @@
// ============================================================================
// linear_longest_prefix_match
// Route table with a linear longest prefix match search over the slots in use.
// ============================================================================
// Usage:
//   The input channel (s_axis_*) carries one word per item. tuser selects the
//   operation: a write stores prefix, mask, next hop and port at a slot and
//   returns nothing; a lookup scans slots 0 to entries_in_use-1 and returns
//   exactly one word on the output channel (m_axis_*).
//   A lookup's scan is set by the table memory's single read port: one slot
//   is read and compared per cycle. The input is not ready during a scan.
//   The result sits in an output register, so the next word is accepted while
//   a result waits. If the receiver stalls past the end of the next scan, the
//   engine holds its finished result until the output register frees.
//   entries_in_use is written through i_cfg_we / i_cfg_wdata, by the user only while idle
//   (the block itself does not enforce this); values above the table depth scan the whole table.
//   Reset clears the control state and entries_in_use. The table is not
//   cleared: a slot must be written before a lookup scans it.
// ============================================================================

`include "linear_longest_prefix_match_macros.svh"

module linear_longest_prefix_match
    import llpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration: entries_in_use.
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // From bit 0 up: entry_index[9:0], entry_prefix[41:10], entry_mask[73:42],
    // entry_next_hop[105:74], entry_port[113:106], lookup_address[145:114],
    // zero pad[151:146].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func: 0 write route, 1 lookup.
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // From bit 0 up: best_next_hop[31:0], best_port[39:32], best_index[49:40],
    // zero pad[55:50].
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // found.
    output logic                 m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // Input word fields.
    logic [SLOT_W-1:0] in_slot;
    t_route            in_route;
    logic [ADDR_W-1:0] in_addr;

    assign in_slot         = s_axis_tdata[9:0];
    assign in_route.prefix   = s_axis_tdata[41:10];
    assign in_route.mask     = s_axis_tdata[73:42];
    assign in_route.hop      = s_axis_tdata[105:74];
    assign in_route.port     = s_axis_tdata[113:106];
    assign in_addr         = s_axis_tdata[145:114];

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [CNT_W-1:0]  r_lim;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic [ADDR_W-1:0] r_addr;

    // Running winner of the current scan.
    logic              r_have;
    logic [ADDR_W-1:0] r_best_mask;
    logic [ADDR_W-1:0] r_best_hop;
    logic [PORT_W-1:0] r_best_port;
    logic [IDX_W-1:0]  r_best_idx;

    // Output register.
    logic                 r_m_valid;
    logic                 r_m_found;
    logic [M_TDATA_W-1:0] r_m_data;

    logic              accept;
    logic              wr_en;
    logic [31:0]       slot_wide;
    logic [31:0]       lim_wide;
    logic [CNT_W-1:0]  lim_sat;
    logic              issue;
    t_route            rd_route;
    logic              hit;
    logic              take;
    logic              out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A write beyond the table is dropped.
    assign slot_wide = 32'(in_slot);
    assign wr_en     = accept && (s_axis_tuser == FUNC_WRITE) && (slot_wide < TABLE_DEPTH);

    // The scan length saturates at the table depth.
    assign lim_wide = (32'(r_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(r_cfg);
    assign lim_sat  = lim_wide[CNT_W-1:0];

    assign issue = (r_state == ST_SCAN) && (r_cnt < r_lim);

    llpm_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (slot_wide[IDX_W-1:0]),
        .i_wdata (in_route),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_route)
    );

    // A slot replaces the winner only with a strictly larger mask, so on a tie
    // the earlier slot stays.
    assign hit  = (r_addr & rd_route.mask) == rd_route.prefix;
    assign take = r_pend && hit && (!r_have || (rd_route.mask > r_best_mask));

    assign out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (s_axis_tuser == FUNC_LOOKUP)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= '0;
            r_lim     <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_have    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end

            // Start of a lookup: latch the address and clear the winner.
            if (accept && (s_axis_tuser == FUNC_LOOKUP)) begin
                r_lim  <= lim_sat;
                r_cnt  <= '0;
                r_pend <= 1'b0;
                r_have <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_pend <= issue;
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (take) begin
                    r_have <= 1'b1;
                end
            end

            if (r_state == ST_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept && (s_axis_tuser == FUNC_LOOKUP)) begin
            r_addr      <= in_addr;
            r_best_mask <= '0;
            r_best_hop  <= '0;
            r_best_port <= '0;
            r_best_idx  <= '0;
        end else if (r_state == ST_SCAN) begin
            r_pidx <= r_cnt[IDX_W-1:0];
            if (take) begin
                r_best_mask <= rd_route.mask;
                r_best_hop  <= rd_route.hop;
                r_best_port <= rd_route.port;
                r_best_idx  <= r_pidx;
            end
        end

        if (r_state == ST_FIN && out_free) begin
            r_m_found <= r_have;
            r_m_data  <= {6'd0, SLOT_W'(32'(r_best_idx)), r_best_port, r_best_hop};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_found;

    // The scan never reads past its limit.
    `LLPM_ASSERT(a_cnt_in_limit, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (r_cnt <= r_lim))
    // A compare only follows a read issued during the scan.
    `LLPM_ASSERT(a_pend_from_scan, i_clk, i_rst_n, r_pend |-> $past(r_state == ST_SCAN))
    // A finished scan that hands off its result returns to idle with it shown.
    `LLPM_ASSERT(a_fin_loads, i_clk, i_rst_n,
        (r_state == ST_FIN && out_free) |=> (r_m_valid && r_state == ST_IDLE))
    // A miss carries all-zero fields.
    `LLPM_ASSERT(a_miss_zero, i_clk, i_rst_n, (r_m_valid && !r_m_found) |-> (r_m_data == '0))
    // Writes only happen while idle, never under a running scan.
    `LLPM_ASSERT_ALWAYS(a_write_idle, i_clk, wr_en |-> (r_state == ST_IDLE))

endmodule
